// ===== rtl/core/sorted_priority_queue_top_macros.svh =====
// Assertion macros for the sorted priority queue.
// Used by sorted_priority_queue_top; expects i_clk and i_rst_n in scope.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/spq_pkg.sv =====
// Types and codes shared by the sorted priority queue modules.
// No dependencies.
package spq_pkg;

    localparam int unsigned Depth  = 16;
    localparam int unsigned ValueW = 32;
    localparam int unsigned PrioW  = 16;
    localparam int unsigned KindW  = 2;
    localparam int unsigned StatW  = 2;
    localparam int unsigned CountW = 5;

    typedef enum logic [KindW-1:0] {
        KIND_INSERT = 2'd0,
        KIND_POP    = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    typedef enum logic [StatW-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [KindW-1:0]         kind;
        logic signed [ValueW-1:0] value;
        logic signed [PrioW-1:0]  priority_req;
    } t_in_item;

    typedef struct packed {
        logic signed [ValueW-1:0] popped_value;
        logic signed [PrioW-1:0]  popped_priority;
        logic [StatW-1:0]         status;
        logic [CountW-1:0]        count;
    } t_out_item;

    typedef struct packed {
        logic signed [ValueW-1:0] value;
        logic signed [PrioW-1:0]  prio;
    } t_entry;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic   ins;
        logic   pop;
        t_entry new_entry;
    } t_cell_ctrl;

endpackage

// ===== rtl/core/spq_cell.sv =====
// One cell of the sorted chain: holds a single entry and trades with its neighbours.
// Depends on spq_pkg.
module spq_cell (
    input  logic                i_clk,
    input  logic                i_occ,
    input  logic                i_left_keep,
    input  spq_pkg::t_entry     i_left_entry,
    input  spq_pkg::t_entry     i_right_entry,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    output logic                o_keep,
    output spq_pkg::t_entry     o_entry
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Occupied cells at or below the new priority form a prefix; they hold.
    assign o_keep = i_occ && ($signed(r_entry.prio) <= $signed(i_ctrl.new_entry.prio));

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_left_keep) begin
                n_entry = i_ctrl.new_entry;
            end else begin
                n_entry = i_left_entry;
            end
        end else if (i_ctrl.pop) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/core/spq_out_buf.sv =====
// Result register with a skid stage behind it.
// Depends on spq_pkg.
module spq_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  spq_pkg::t_out_item i_item,
    input  logic               i_stall,
    output logic               o_valid,
    output spq_pkg::t_out_item o_item,
    output logic               o_full
);
    import spq_pkg::*;

    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_skid_valid;
    logic      n_skid_valid;
    t_out_item r_skid;
    t_out_item n_skid;
    logic      w_take;

    assign w_take = r_out_valid && !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            // advance the skid entry once the output is taken
            if (w_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_take) begin
                n_out       = i_item;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_item;
                n_skid_valid = 1'b1;
            end
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;
    assign o_full  = r_skid_valid;

endmodule

// ===== rtl/core/sorted_priority_queue_top.sv =====
// Sorted priority queue: a chain of Depth cells (spq_pkg) kept in ascending priority order,
// equal priorities in arrival order. Every transaction (insert, pop, clear) takes
// effect in the cycle it is accepted and its result is registered in the output
// register or its skid stage; one transaction per cycle is sustained while the input
// is not stalled, since each cell only compares its own priority and copies from a
// neighbour. Input stalls only when the output register and its skid stage are both
// held. Depends on spq_pkg, spq_cell, spq_out_buf and sorted_priority_queue_top_macros.svh.
`include "sorted_priority_queue_top_macros.svh"

module sorted_priority_queue_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  spq_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output spq_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);
    import spq_pkg::*;

    localparam int unsigned CW = $clog2(Depth + 1);

    logic          r_count;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          w_fire;
    logic          w_full;
    logic          w_empty;
    logic          w_skid_full;
    t_cell_ctrl    w_ctrl;
    t_out_item     w_res;
    t_entry        w_entry [Depth];
    logic          w_keep  [Depth];

    assign w_fire  = i_in_valid && !w_skid_full;
    assign w_full  = (r_cnt == CW'(Depth));
    assign w_empty = (r_cnt == '0);

    // r_count flags a non-empty queue, registered beside the count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_count <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_count <= (n_cnt != '0);
        end
    end

    always_comb begin
        n_cnt                  = r_cnt;
        w_ctrl.ins             = 1'b0;
        w_ctrl.pop             = 1'b0;
        w_ctrl.new_entry.value = i_in_item.value;
        w_ctrl.new_entry.prio  = i_in_item.priority_req;
        w_res.popped_value     = '0;
        w_res.popped_priority  = '0;
        w_res.status           = ST_OK;
        unique case (i_in_item.kind)
            KIND_INSERT: begin
                if (w_full) begin
                    w_res.status = ST_FULL;
                end else begin
                    w_ctrl.ins = w_fire;
                    n_cnt      = w_fire ? r_cnt + CW'(1) : r_cnt;
                end
            end
            KIND_POP: begin
                if (w_empty) begin
                    w_res.status = ST_EMPTY;
                end else begin
                    w_ctrl.pop            = w_fire;
                    n_cnt                 = w_fire ? r_cnt - CW'(1) : r_cnt;
                    w_res.popped_value    = w_entry[0].value;
                    w_res.popped_priority = w_entry[0].prio;
                end
            end
            KIND_CLEAR: begin
                n_cnt = w_fire ? '0 : r_cnt;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
        w_res.count = CountW'(n_cnt);
    end

    for (genvar g = 0; g < Depth; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_keep;

        if (g == 0) begin : g_head
            assign w_left      = w_ctrl.new_entry;
            assign w_left_keep = 1'b1;
        end else begin : g_body
            assign w_left      = w_entry[g-1];
            assign w_left_keep = w_keep[g-1];
        end

        if (g == Depth - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_mid
            assign w_right = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_occ        (CW'(g) < r_cnt),
            .i_left_keep  (w_left_keep),
            .i_left_entry (w_left),
            .i_right_entry(w_right),
            .i_ctrl       (w_ctrl),
            .o_keep       (w_keep[g]),
            .o_entry      (w_entry[g])
        );
    end

    spq_out_buf u_out_buf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_fire),
        .i_item (w_res),
        .i_stall(i_out_stall),
        .o_valid(o_out_valid),
        .o_item (o_out_item),
        .o_full (w_skid_full)
    );

    assign o_in_stall = w_skid_full;

    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, r_cnt <= CW'(Depth), "entry count above depth")
    `SPQ_ASSERT_NOW(a_flag_match, 1'b1, r_count == (r_cnt != '0),
        "non-empty flag out of step")
    `SPQ_ASSERT_NEXT(a_pop_count, w_fire && (i_in_item.kind == KIND_POP) && !w_empty,
        r_cnt == $past(r_cnt) - CW'(1), "pop did not drop the count")
    `SPQ_ASSERT_NOW(a_head_sorted, r_cnt >= CW'(2),
        $signed(w_entry[0].prio) <= $signed(w_entry[1].prio), "head entries out of order")
    `SPQ_ASSERT_NOW(a_skid_order, w_skid_full, o_out_valid, "skid held without output")

endmodule
